// ===== hdl/json_stream_pretty_printer_core_macros.svh =====
// Assertion macros shared by the pretty printer RTL.
// Included by every module that carries concurrent checks.
`ifndef JSON_STREAM_PRETTY_PRINTER_CORE_MACROS_SVH
`define JSON_STREAM_PRETTY_PRINTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSPP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("jspp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define JSPP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("jspp assertion failed");

`endif

// ===== hdl/jspp_pkg.sv =====
// Shared types and constants of the JSON pretty printer.
// No dependencies; imported by all jspp modules and the core top level.
`timescale 1ns / 1ps
`default_nettype none
package jspp_pkg;

    localparam int BYTE_W      = 8;
    localparam int DEPTH_W     = 8;
    localparam int SPACE_W     = 16;
    localparam int CNT_W       = 2;

    localparam int DEF_MAX_DEPTH   = 255;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] INDENT_RESET = 8'd4;

    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_BREAK = 1'b1;

    // One classified input byte: optional line break, then one character,
    // the " : " triple or nothing.
    typedef struct packed {
        logic               brk;
        logic               chr_en;
        logic               colon;
        logic [BYTE_W-1:0]  chr;
        logic [SPACE_W-1:0] spaces;
    } t_cmd;

endpackage
`default_nettype wire

// ===== hdl/jspp_front.sv =====
// Front end: classifies each accepted byte, tracks nesting and string
// state, and builds at most one command. Depends on jspp_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "json_stream_pretty_printer_core_macros.svh"
module jspp_front #(
    parameter int MAX_DEPTH = jspp_pkg::DEF_MAX_DEPTH
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_accept,
    input  wire  [jspp_pkg::BYTE_W-1:0] i_in_byte,
    input  wire                         i_end_of_stream,
    input  wire                         i_cfg_we,
    input  wire  [jspp_pkg::BYTE_W-1:0] i_cfg_data,
    output logic                        o_cmd_valid,
    output jspp_pkg::t_cmd              o_cmd
);
    import jspp_pkg::*;

    localparam logic [DEPTH_W-1:0] MAX_D = DEPTH_W'(MAX_DEPTH);

    logic [BYTE_W-1:0]  r_indent;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_in_str, n_in_str;
    logic               r_esc, n_esc;
    logic               r_pend, n_pend;

    logic               quote_live;
    logic               do_fmt;
    logic               do_plain;
    logic [DEPTH_W-1:0] brk_depth;
    t_cmd               cmd;

    always_comb begin
        cmd        = '0;
        cmd.chr    = i_in_byte;
        n_depth    = r_depth;
        n_in_str   = r_in_str;
        n_esc      = r_esc;
        n_pend     = r_pend;
        brk_depth  = r_depth;
        quote_live = (i_in_byte == CH_QUOTE) && !r_esc;
        do_fmt     = 1'b0;
        do_plain   = 1'b0;
        o_cmd_valid = 1'b0;

        if (i_end_of_stream) begin
            cmd.brk     = 1'b1;
            brk_depth   = '0;
            o_cmd_valid = 1'b1;
        end else if (i_in_byte != CH_CR && i_in_byte != CH_LF) begin
            do_fmt   = quote_live ||
                       (!r_in_str && i_in_byte != CH_SPACE && i_in_byte != CH_TAB);
            do_plain = !quote_live && r_in_str;
            if (do_fmt) begin
                unique case (i_in_byte) inside
                    CH_LBRACE, CH_LBRACK: begin
                        cmd.brk    = r_pend;
                        cmd.chr_en = 1'b1;
                        if (r_depth < MAX_D) begin
                            n_depth = r_depth + 1'b1;
                        end
                        n_pend = 1'b1;
                    end
                    CH_RBRACE, CH_RBRACK: begin
                        if (r_depth != '0) begin
                            n_depth = r_depth - 1'b1;
                        end
                        brk_depth  = n_depth;
                        cmd.brk    = 1'b1;
                        cmd.chr_en = 1'b1;
                        n_pend     = 1'b1;
                    end
                    CH_COMMA: begin
                        cmd.chr_en = 1'b1;
                        n_pend     = 1'b1;
                    end
                    CH_COLON: begin
                        cmd.colon = 1'b1;
                    end
                    default: begin
                        cmd.brk    = r_pend;
                        cmd.chr_en = 1'b1;
                        n_pend     = 1'b0;
                    end
                endcase
            end else if (do_plain) begin
                cmd.chr_en = 1'b1;
            end
            o_cmd_valid = do_fmt || do_plain;
            if (quote_live) begin
                n_in_str = !r_in_str;
            end
            n_esc = (i_in_byte == CH_BSLASH) ? !r_esc : 1'b0;
        end
        cmd.spaces = SPACE_W'(brk_depth) * SPACE_W'(r_indent);
        o_cmd      = cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_indent <= INDENT_RESET;
            r_depth  <= '0;
            r_in_str <= 1'b0;
            r_esc    <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_indent <= i_cfg_data;
            end
            if (i_accept) begin
                r_depth  <= n_depth;
                r_in_str <= n_in_str;
                r_esc    <= n_esc;
                r_pend   <= n_pend;
            end
        end
    end

    `JSPP_ASSERT_IMP(a_depth_cap, i_clk, i_rst_n, 1'b1, r_depth <= MAX_D)
    `JSPP_ASSERT_NXT(a_idle_hold, i_clk, i_rst_n, !i_accept,
                     r_depth == $past(r_depth) && r_in_str == $past(r_in_str))

endmodule
`default_nettype wire

// ===== hdl/jspp_cmdq.sv =====
// Short command queue between the front end and the emitter.
// Depends on jspp_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "json_stream_pretty_printer_core_macros.svh"
module jspp_cmdq #(
    parameter int DEPTH = jspp_pkg::DEF_QUEUE_DEPTH
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  jspp_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  wire            i_pop,
    output logic           o_empty,
    output jspp_pkg::t_cmd o_cmd
);
    import jspp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

    t_cmd              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_QW-1:0] r_cnt;
    logic              do_wr, do_rd;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_wr   = i_push && !o_full;
    assign do_rd   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_rd) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `JSPP_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= FULL_CNT)
    `JSPP_ASSERT_NXT(a_cnt_track, i_clk, i_rst_n, do_wr && !do_rd, r_cnt == $past(r_cnt) + 1'b1)

endmodule
`default_nettype wire

// ===== hdl/jspp_back.sv =====
// Emitter: takes commands from the queue and plays them out as one result
// per cycle while pop is high. Depends on jspp_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "json_stream_pretty_printer_core_macros.svh"
module jspp_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_q_empty,
    input  jspp_pkg::t_cmd               i_q_cmd,
    output logic                         o_q_pop,
    input  wire                          pop,
    output logic                         empty,
    output logic                         o_kind,
    output logic [jspp_pkg::BYTE_W-1:0]  o_out_byte,
    output logic [jspp_pkg::SPACE_W-1:0] o_space_count,
    output logic                         o_last
);
    import jspp_pkg::*;

    localparam logic [CNT_W-1:0] CNT_TRIPLE = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_MID    = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

    t_cmd             r_cmd;
    logic             r_busy;
    logic             r_brk;
    logic [CNT_W-1:0] r_cnt;
    logic             take;
    logic             load;

    always_comb begin
        empty         = !r_busy;
        o_kind        = KIND_CHAR;
        o_out_byte    = '0;
        o_space_count = '0;
        o_last        = 1'b0;
        if (r_brk) begin
            o_kind        = KIND_BREAK;
            o_space_count = r_cmd.spaces;
            o_last        = (r_cnt == '0);
        end else begin
            o_out_byte = r_cmd.chr;
            if (r_cmd.colon) begin
                // " : " is played out with the colon in the middle slot
                o_out_byte = (r_cnt == CNT_MID) ? CH_COLON : CH_SPACE;
            end
            o_last = (r_cnt == CNT_ONE);
        end
    end

    assign take    = pop && r_busy;
    assign load    = !r_busy || (take && o_last);
    assign o_q_pop = load && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_brk  <= 1'b0;
            r_cnt  <= '0;
        end else if (load) begin
            r_busy <= !i_q_empty;
            r_brk  <= !i_q_empty && i_q_cmd.brk;
            if (i_q_empty) begin
                r_cnt <= '0;
            end else if (i_q_cmd.colon) begin
                r_cnt <= CNT_TRIPLE;
            end else begin
                r_cnt <= CNT_W'(i_q_cmd.chr_en);
            end
        end else if (take) begin
            if (r_brk) begin
                r_brk <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `JSPP_ASSERT_NXT(a_more_follows, i_clk, i_rst_n, take && !o_last, !empty)
    `JSPP_ASSERT_IMP(a_char_left, i_clk, i_rst_n, r_busy && !r_brk, r_cnt != '0)
    `JSPP_ASSERT_IMP(a_idle_clean, i_clk, i_rst_n, !r_busy, !r_brk && r_cnt == '0)

endmodule
`default_nettype wire

// ===== hdl/json_stream_pretty_printer_core.sv =====
// JSON pretty printer: one text byte in per request, formatted results out,
// each a character or a line break followed by depth * indent spaces.
// An input byte is taken every cycle while full is low; each byte gives zero
// to three results and the emitter delivers one result per cycle while pop
// is high. A byte's command is registered in the command queue, then in the
// emitter register, before its first result appears. indent_width is written
// through i_cfg_we / i_cfg_data and should only change while the block is
// idle. No clearing pass: the block is ready as soon as reset is released.
// Depends on jspp_pkg, jspp_front, jspp_cmdq and jspp_back.
`timescale 1ns / 1ps
`default_nettype none
module json_stream_pretty_printer_core #(
    parameter int MAX_DEPTH   = jspp_pkg::DEF_MAX_DEPTH,
    parameter int QUEUE_DEPTH = jspp_pkg::DEF_QUEUE_DEPTH
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          push,
    output logic                         full,
    input  wire  [jspp_pkg::BYTE_W-1:0]  i_in_byte,
    input  wire                          i_end_of_stream,
    input  wire                          i_cfg_we,
    input  wire  [jspp_pkg::BYTE_W-1:0]  i_cfg_data,
    output logic                         empty,
    input  wire                          pop,
    output logic                         o_kind,
    output logic [jspp_pkg::BYTE_W-1:0]  o_out_byte,
    output logic [jspp_pkg::SPACE_W-1:0] o_space_count,
    output logic                         o_last
);
    import jspp_pkg::*;

    logic accept;
    logic cmd_valid;
    t_cmd front_cmd;
    t_cmd q_cmd;
    logic q_full, q_empty, q_pop;

    assign full   = q_full;
    assign accept = push && !q_full;

    jspp_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (front_cmd)
    );

    jspp_cmdq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && cmd_valid),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    jspp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .pop           (pop),
        .empty         (empty),
        .o_kind        (o_kind),
        .o_out_byte    (o_out_byte),
        .o_space_count (o_space_count),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire
